[rtl/ppa_pkg.sv]
// Package for the palette packed array: state encoding, command codes,
// field widths and the request struct for the field unit. No dependencies.
`default_nettype none

package ppa_pkg;

	localparam int CMD_W     = 2;
	localparam int POS_W     = 14;
	localparam int CODE_W    = 12;
	localparam int VALUE_W   = 32;
	localparam int WIDTH_W   = 4;
	localparam int BYTE_W    = 8;
	localparam int OFF_W     = 3;
	localparam int WIN_BITS  = 24;
	localparam int SHIFT_W   = 5;
	localparam int START_W   = POS_W + WIDTH_W;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 4'd8;
	localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 4'd1;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 4'd12;

	localparam logic [CMD_W-1:0] CMD_READ       = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_CODE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE_PAL  = 2'd2;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CHECK,
		S_RD_ISSUE,
		S_RD_CAP,
		S_EXTRACT,
		S_PAL_CAP,
		S_MERGE,
		S_WR_BYTE,
		S_DONE
	} state_t;

	// Placement of one element's code inside the byte window.
	typedef struct packed {
		logic [OFF_W-1:0]   off;
		logic [WIDTH_W-1:0] width;
	} field_req_t;

endpackage

`default_nettype wire

[rtl/ppa_ram.sv]
// Single-port RAM with registered read data, used for the packed code bytes
// and for the palette words. No dependencies.
`default_nettype none

module ppa_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/ppa_field_unit.sv]
// Shared shift unit: extracts a code from the three-byte window and merges a
// new code into it. Depends on ppa_pkg.
`default_nettype none

module ppa_field_unit (
	input  wire logic [ppa_pkg::WIN_BITS-1:0] window,
	input  wire ppa_pkg::field_req_t          req,
	input  wire logic [ppa_pkg::CODE_W-1:0]   code_in,
	output logic      [ppa_pkg::CODE_W-1:0]   code_ext,
	output logic      [ppa_pkg::WIN_BITS-1:0] window_merged
);

	logic [ppa_pkg::SHIFT_W-1:0]  sh;
	logic [ppa_pkg::CODE_W-1:0]   mask;
	logic [ppa_pkg::WIN_BITS-1:0] mask_win;
	logic [ppa_pkg::WIN_BITS-1:0] code_win;
	logic [ppa_pkg::WIN_BITS-1:0] win_shr;

	// The window holds the element's bytes with the first byte at the top.
	assign sh = ppa_pkg::SHIFT_W'(ppa_pkg::WIN_BITS) - ppa_pkg::SHIFT_W'(req.off)
		- ppa_pkg::SHIFT_W'(req.width);
	assign mask = ppa_pkg::CODE_W'((13'd1 << req.width) - 13'd1);
	assign mask_win = ppa_pkg::WIN_BITS'(mask) << sh;
	assign code_win = ppa_pkg::WIN_BITS'(code_in & mask) << sh;
	assign win_shr = window >> sh;
	assign code_ext = win_shr[ppa_pkg::CODE_W-1:0] & mask;
	assign window_merged = (window & ~mask_win) | code_win;

endmodule

`default_nettype wire

[rtl/palette_packed_array_unit.sv]
// Top level of the palette packed array: sequencer, code byte store, palette
// store and shared field unit. Depends on ppa_pkg, ppa_ram, ppa_field_unit.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   cfg     | cfg_valid cfg_ready cfg_data[3:0]     | in
//   in      | in_valid in_ready cmd position code   | in
//           | value                                 |
//   out     | out_valid out_ready code_out value_out| out
//           | status                                |
//
// A read decodes and checks the word, reads and captures each of the n
// (1 to 3) code store bytes the element touches, extracts the code and
// reads the palette word. A code write captures the bytes the same way,
// merges the new code and writes each byte back. Palette writes, range
// errors found in the check and the unused command end after the check.
// Reset sets code_width to 8 and empties the output register; both stores
// hold no defined content until written, and there is no clearing pass.
// The block takes one word at a time, but it accepts the next word while a
// finished result still waits in the output register.
`default_nettype none

module palette_packed_array_unit #(
	parameter int ELEMENTS         = 16384,
	parameter int PALETTE_DEPTH    = 4096,
	parameter int CODE_STORE_BYTES = 24576
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ppa_pkg::WIDTH_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ppa_pkg::CMD_W-1:0]     cmd,
	input  wire logic [ppa_pkg::POS_W-1:0]     position,
	input  wire logic [ppa_pkg::CODE_W-1:0]    code,
	input  wire logic [ppa_pkg::VALUE_W-1:0]   value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [ppa_pkg::CODE_W-1:0]    code_out,
	output logic      [ppa_pkg::VALUE_W-1:0]   value_out,
	output logic                               status
);

	localparam int CODE_AW = (CODE_STORE_BYTES > 1) ? $clog2(CODE_STORE_BYTES) : 1;
	localparam int PAL_AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	ppa_pkg::state_t state_q, state_d;

	logic [ppa_pkg::WIDTH_W-1:0] code_width_q;
	logic [ppa_pkg::WIDTH_W-1:0] w_eff;

	// Latched command and working registers.
	logic [ppa_pkg::CMD_W-1:0]    cmd_q;
	logic [ppa_pkg::POS_W-1:0]    pos_q;
	logic [ppa_pkg::CODE_W-1:0]   code_q;
	logic [ppa_pkg::VALUE_W-1:0]  value_q;
	logic [ppa_pkg::WIDTH_W-1:0]  w_q;
	logic [ppa_pkg::START_W-1:0]  start_q;
	logic [1:0]                   nbytes_q;
	logic [1:0]                   cnt_q;
	logic [ppa_pkg::WIN_BITS-1:0] window_q;

	// Result being built, and the output register.
	logic [ppa_pkg::CODE_W-1:0]  res_code_q;
	logic [ppa_pkg::VALUE_W-1:0] res_value_q;
	logic                        res_status_q;
	logic                        out_valid_q;
	logic [ppa_pkg::CODE_W-1:0]  code_out_q;
	logic [ppa_pkg::VALUE_W-1:0] value_out_q;
	logic                        status_q;

	logic in_accept;
	logic out_load;
	logic elem_ok;
	logic pal_ok;
	logic ext_ok;
	logic last_byte;
	logic [1:0]  nbytes_calc;
	logic [31:0] end_bytes;
	logic [31:0] byte_idx;
	logic [31:0] pal_idx;

	ppa_pkg::field_req_t          freq;
	logic [ppa_pkg::CODE_W-1:0]   code_ext;
	logic [ppa_pkg::WIN_BITS-1:0] window_merged;
	logic [ppa_pkg::BYTE_W-1:0]   wr_byte;

	logic                         code_en, code_we;
	logic [CODE_AW-1:0]           code_addr;
	logic [ppa_pkg::BYTE_W-1:0]   code_rdata;
	logic                         pal_en, pal_we;
	logic [PAL_AW-1:0]            pal_addr;
	logic [ppa_pkg::VALUE_W-1:0]  pal_rdata;

	// Configuration is always accepted; the user must send it only while the block idles (not enforced here).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_width_q <= ppa_pkg::WIDTH_RESET;
		end else if (cfg_valid) begin
			code_width_q <= cfg_data;
		end
	end

	// Width zero acts as one bit, and widths above twelve act as twelve.
	always_comb begin
		priority if (code_width_q == '0) begin
			w_eff = ppa_pkg::WIDTH_MIN;
		end else if (code_width_q > ppa_pkg::WIDTH_MAX) begin
			w_eff = ppa_pkg::WIDTH_MAX;
		end else begin
			w_eff = code_width_q;
		end
	end

	assign in_accept = in_valid && in_ready;
	assign out_load  = (state_q == ppa_pkg::S_DONE) && (!out_valid_q || out_ready);

	// Range checks on the registered start bit.
	assign end_bytes = (32'(start_q) + 32'(w_q) + 32'd7) >> 3;
	assign elem_ok = (32'(pos_q) < ELEMENTS) && (end_bytes <= CODE_STORE_BYTES);
	assign pal_ok  = 32'(pos_q) < PALETTE_DEPTH;
	assign nbytes_calc = 2'((5'(start_q[2:0]) + 5'(w_q) + 5'd7) >> 3);
	assign last_byte = (cnt_q + 2'd1) == nbytes_q;

	assign freq.off   = start_q[2:0];
	assign freq.width = w_q;
	assign ext_ok = 32'(code_ext) < PALETTE_DEPTH;

	assign byte_idx = 32'(start_q >> 3) + 32'(cnt_q);
	assign pal_idx  = (state_q == ppa_pkg::S_EXTRACT) ? 32'(code_ext) : 32'(pos_q);

	always_comb begin
		unique case (cnt_q)
			2'd0:    wr_byte = window_q[23:16];
			2'd1:    wr_byte = window_q[15:8];
			default: wr_byte = window_q[7:0];
		endcase
	end

	ppa_field_unit u_field (
		.window        (window_q),
		.req           (freq),
		.code_in       (code_q),
		.code_ext      (code_ext),
		.window_merged (window_merged)
	);

	ppa_ram #(
		.WIDTH  (ppa_pkg::BYTE_W),
		.DEPTH  (CODE_STORE_BYTES),
		.ADDR_W (CODE_AW)
	) u_code_ram (
		.clk   (clk),
		.en    (code_en),
		.we    (code_we),
		.addr  (code_addr),
		.wdata (wr_byte),
		.rdata (code_rdata)
	);

	ppa_ram #(
		.WIDTH  (ppa_pkg::VALUE_W),
		.DEPTH  (PALETTE_DEPTH),
		.ADDR_W (PAL_AW)
	) u_pal_ram (
		.clk   (clk),
		.en    (pal_en),
		.we    (pal_we),
		.addr  (pal_addr),
		.wdata (value_q),
		.rdata (pal_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppa_pkg::S_IDLE: begin
				if (in_valid) state_d = ppa_pkg::S_DECODE;
			end
			ppa_pkg::S_DECODE: begin
				state_d = ppa_pkg::S_CHECK;
			end
			ppa_pkg::S_CHECK: begin
				if ((cmd_q == ppa_pkg::CMD_READ || cmd_q == ppa_pkg::CMD_WRITE_CODE)
					&& elem_ok) begin
					state_d = ppa_pkg::S_RD_ISSUE;
				end else begin
					state_d = ppa_pkg::S_DONE;
				end
			end
			ppa_pkg::S_RD_ISSUE: begin
				state_d = ppa_pkg::S_RD_CAP;
			end
			ppa_pkg::S_RD_CAP: begin
				if (!last_byte) begin
					state_d = ppa_pkg::S_RD_ISSUE;
				end else if (cmd_q == ppa_pkg::CMD_READ) begin
					state_d = ppa_pkg::S_EXTRACT;
				end else begin
					state_d = ppa_pkg::S_MERGE;
				end
			end
			ppa_pkg::S_EXTRACT: begin
				state_d = ext_ok ? ppa_pkg::S_PAL_CAP : ppa_pkg::S_DONE;
			end
			ppa_pkg::S_PAL_CAP: begin
				state_d = ppa_pkg::S_DONE;
			end
			ppa_pkg::S_MERGE: begin
				state_d = ppa_pkg::S_WR_BYTE;
			end
			ppa_pkg::S_WR_BYTE: begin
				if (last_byte) state_d = ppa_pkg::S_DONE;
			end
			ppa_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) state_d = ppa_pkg::S_IDLE;
			end
			default: begin
				state_d = ppa_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: handshake and memory controls.
	always_comb begin
		in_ready  = 1'b0;
		code_en   = 1'b0;
		code_we   = 1'b0;
		pal_en    = 1'b0;
		pal_we    = 1'b0;
		code_addr = byte_idx[CODE_AW-1:0];
		pal_addr  = pal_idx[PAL_AW-1:0];
		unique case (state_q)
			ppa_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			ppa_pkg::S_CHECK: begin
				if (cmd_q == ppa_pkg::CMD_WRITE_PAL && pal_ok) begin
					pal_en = 1'b1;
					pal_we = 1'b1;
				end
			end
			ppa_pkg::S_RD_ISSUE: begin
				code_en = 1'b1;
			end
			ppa_pkg::S_EXTRACT: begin
				pal_en = ext_ok;
			end
			ppa_pkg::S_WR_BYTE: begin
				code_en = 1'b1;
				code_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppa_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers; the sequencer state decides what each one loads.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q   <= cmd;
			pos_q   <= position;
			code_q  <= code;
			value_q <= value;
			w_q     <= w_eff;
		end
		unique case (state_q)
			ppa_pkg::S_DECODE: begin
				start_q      <= ppa_pkg::START_W'(pos_q) * ppa_pkg::START_W'(w_q);
				res_code_q   <= '0;
				res_value_q  <= '0;
				res_status_q <= ppa_pkg::STATUS_OK;
			end
			ppa_pkg::S_CHECK: begin
				nbytes_q <= nbytes_calc;
				cnt_q    <= '0;
				window_q <= '0;
				if (cmd_q == ppa_pkg::CMD_READ || cmd_q == ppa_pkg::CMD_WRITE_CODE) begin
					if (!elem_ok) res_status_q <= ppa_pkg::STATUS_RANGE;
				end else if (cmd_q == ppa_pkg::CMD_WRITE_PAL) begin
					if (!pal_ok) res_status_q <= ppa_pkg::STATUS_RANGE;
				end
			end
			ppa_pkg::S_RD_CAP: begin
				unique case (cnt_q)
					2'd0:    window_q[23:16] <= code_rdata;
					2'd1:    window_q[15:8]  <= code_rdata;
					default: window_q[7:0]   <= code_rdata;
				endcase
				cnt_q <= cnt_q + 2'd1;
			end
			ppa_pkg::S_EXTRACT: begin
				res_code_q <= code_ext;
				if (!ext_ok) res_status_q <= ppa_pkg::STATUS_RANGE;
			end
			ppa_pkg::S_PAL_CAP: begin
				res_value_q <= pal_rdata;
			end
			ppa_pkg::S_MERGE: begin
				window_q <= window_merged;
				cnt_q    <= '0;
			end
			ppa_pkg::S_WR_BYTE: begin
				cnt_q <= cnt_q + 2'd1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			code_out_q  <= res_code_q;
			value_out_q <= res_value_q;
			status_q    <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign code_out  = code_out_q;
	assign value_out = value_out_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	a_cap_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppa_pkg::S_RD_CAP) |-> (cnt_q < nbytes_q && nbytes_q != 2'd0))
		else $error("byte capture beyond the element's bytes");
	a_wr_only_code: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppa_pkg::S_WR_BYTE) |-> (cmd_q == ppa_pkg::CMD_WRITE_CODE))
		else $error("code store written by a command that is not a code write");
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ppa_pkg::S_DECODE))
		else $error("accepted word did not start decoding");
	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ppa_pkg::STATUS_RANGE) |-> (value_out_q == '0))
		else $error("range error with nonzero palette word");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(code_out_q) && $stable(status_q))
		else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire
